FILE: sv/bicubic_bezier_patch_eval_assert.svh
// Assertion macros for the bicubic Bezier patch evaluator.
`ifndef BICUBIC_BEZIER_PATCH_EVAL_ASSERT_SVH
`define BICUBIC_BEZIER_PATCH_EVAL_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BBPE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BBPE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/bbpe_pkg.sv
// Shared types and constants of the bicubic Bezier patch evaluator.
`timescale 1ns / 1ps
package bbpe_pkg;

	// Control point grid
	localparam int NUM_POINTS = 16;
	localparam int IDX_W      = 4;
	localparam logic [IDX_W-1:0] FIRST_IDX = 4'd0;
	localparam logic [IDX_W-1:0] LAST_IDX  = 4'd15;

	// Coordinates per point (x, y, z)
	localparam int NUM_LANES = 3;

	// Item operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	// Control from the sequencer to the point memory / accumulator
	typedef struct packed {
		logic             start;
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
	} mac_ctl_t;

endpackage

FILE: sv/bbpe_basis.sv
// Cubic Bernstein weight unit: six steps on one shared multiplier.
`timescale 1ns / 1ps
module bbpe_basis #(
	parameter int F = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [F:0] param,
	output logic       done,
	output logic [F:0] weight [4]
);
	import bbpe_pkg::*;

	localparam int PRODW = 2 * F + 2;
	localparam int TRIPW = 2 * F + 4;
	localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
	localparam logic [TRIPW-1:0] HALF = TRIPW'(1) << (F - 1);

	// Step codes
	localparam logic [2:0] STEP_TT = 3'd0;
	localparam logic [2:0] STEP_SS = 3'd1;
	localparam logic [2:0] STEP_B0 = 3'd2;
	localparam logic [2:0] STEP_B1 = 3'd3;
	localparam logic [2:0] STEP_B2 = 3'd4;
	localparam logic [2:0] STEP_B3 = 3'd5;

	logic [2:0]       step_q;
	logic             busy_q;
	logic             done_q;
	logic [F:0]       t_q, s_q, t2_q, s2_q;
	logic [F:0]       w_q [4];
	logic [F:0]       t_clamp;
	logic [F:0]       op_a, op_b;
	logic             triple;
	logic [PRODW-1:0] prod;
	logic [TRIPW-1:0] ext;
	logic [TRIPW-1:0] rsum;
	logic [F:0]       rnd;

	// Parameters above one count as one
	assign t_clamp = (param[F] && (|param[F-1:0])) ? ONE : param;

	// Operand select per step
	always_comb begin
		op_a   = t_q;
		op_b   = t_q;
		triple = 1'b0;
		unique case (step_q)
			STEP_TT: begin
				op_a = t_q;
				op_b = t_q;
			end
			STEP_SS: begin
				op_a = s_q;
				op_b = s_q;
			end
			STEP_B0: begin
				op_a = s2_q;
				op_b = s_q;
			end
			STEP_B1: begin
				op_a   = t_q;
				op_b   = s2_q;
				triple = 1'b1;
			end
			STEP_B2: begin
				op_a   = t2_q;
				op_b   = s_q;
				triple = 1'b1;
			end
			STEP_B3: begin
				op_a = t2_q;
				op_b = t_q;
			end
			default: begin
				op_a = t_q;
				op_b = t_q;
			end
		endcase
	end

	// Multiply, optional times three, round to nearest
	assign prod = PRODW'(op_a) * PRODW'(op_b);
	assign ext  = triple ? (TRIPW'(prod) + (TRIPW'(prod) << 1)) : TRIPW'(prod);
	assign rsum = ext + HALF;
	assign rnd  = rsum[F +: F + 1];

	// Step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_TT;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= STEP_TT;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (step_q == STEP_B3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 3'd1;
			end
		end
	end

	// Intermediate and weight registers
	always_ff @(posedge clk) begin
		if (start) begin
			t_q <= t_clamp;
			s_q <= ONE - t_clamp;
		end else if (busy_q) begin
			case (step_q)
				STEP_TT: t2_q   <= rnd;
				STEP_SS: s2_q   <= rnd;
				STEP_B0: w_q[0] <= rnd;
				STEP_B1: w_q[1] <= rnd;
				STEP_B2: w_q[2] <= rnd;
				STEP_B3: w_q[3] <= rnd;
				default: ;
			endcase
		end
	end

	assign done   = done_q;
	assign weight = w_q;

endmodule

FILE: sv/bbpe_mac.sv
// Control point memory with the weighted multiply-accumulate pipeline.
`timescale 1ns / 1ps
module bbpe_mac #(
	parameter int C = 24,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bbpe_pkg::mac_ctl_t  ctl,
	input  logic signed [C-1:0] wr_x,
	input  logic signed [C-1:0] wr_y,
	input  logic signed [C-1:0] wr_z,
	input  logic [F:0]          bu [4],
	input  logic [F:0]          bv [4],
	output logic                done,
	output logic signed [C-1:0] res_x,
	output logic signed [C-1:0] res_y,
	output logic signed [C-1:0] res_z
);
	import bbpe_pkg::*;

	localparam int WPW   = 2 * F + 2;
	localparam int PRW   = C + F + 2;
	localparam int ACC_W = C + F + 6;
	localparam logic [WPW-1:0] HALF_W = WPW'(1) << (F - 1);
	localparam logic signed [ACC_W-1:0] HALF_A = ACC_W'(1) << (F - 1);

	// Point storage: x, y, z packed high to low; unwritten entries read as zero
	logic [NUM_LANES*C-1:0] mem_q [NUM_POINTS];
	logic [NUM_POINTS-1:0]  valid_q;

	// Read sequencer
	logic             run_q;
	logic [IDX_W-1:0] cnt_q;

	// Pipeline
	logic                   act_s1, vld_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [NUM_LANES*C-1:0] rd_s1;
	logic                   act_s2, first_s2, last_s2;
	logic [F:0]             w_s2;
	logic signed [C-1:0]    pt_s2 [NUM_LANES];
	logic                   act_s3, first_s3, last_s3;
	logic signed [PRW-1:0]  prod_s3 [NUM_LANES];
	logic signed [ACC_W-1:0] acc_q [NUM_LANES];
	logic                   done_s4;
	logic                   done_q;
	logic signed [C-1:0]    res_q [NUM_LANES];

	logic [WPW-1:0]          wprod, wsum;
	logic signed [ACC_W-1:0] fin_sum [NUM_LANES];
	logic signed [ACC_W-1:0] fin_sh  [NUM_LANES];
	logic signed [C-1:0]     fin_val [NUM_LANES];

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[ctl.wr_idx] <= {wr_x, wr_y, wr_z};
		end
		if (run_q) begin
			rd_s1 <= mem_q[cnt_q];
		end
	end

	// Written flags, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.wr_en) begin
			valid_q[ctl.wr_idx] <= 1'b1;
		end
	end

	// Sequencer and pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			cnt_q   <= FIRST_IDX;
			act_s1  <= 1'b0;
			act_s2  <= 1'b0;
			act_s3  <= 1'b0;
			done_s4 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (ctl.start) begin
				run_q <= 1'b1;
				cnt_q <= FIRST_IDX;
			end else if (run_q) begin
				if (cnt_q == LAST_IDX) begin
					run_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
			act_s1  <= run_q;
			act_s2  <= act_s1;
			act_s3  <= act_s2;
			done_s4 <= act_s3 && last_s3;
			done_q  <= done_s4;
		end
	end

	// Point weight: column weight of u times row weight of v
	assign wprod = WPW'(bu[idx_s1[1:0]]) * WPW'(bv[idx_s1[3:2]]);
	assign wsum  = wprod + HALF_W;

	// Stage payload
	always_ff @(posedge clk) begin
		idx_s1   <= cnt_q;
		vld_s1   <= valid_q[cnt_q];
		w_s2     <= wsum[F +: F + 1];
		first_s2 <= (idx_s1 == FIRST_IDX);
		last_s2  <= (idx_s1 == LAST_IDX);
		first_s3 <= first_s2;
		last_s3  <= last_s2;
		for (int i = 0; i < NUM_LANES; i++) begin
			pt_s2[i]   <= vld_s1 ? $signed(rd_s1[(NUM_LANES - i) * C - 1 -: C]) : '0;
			prod_s3[i] <= pt_s2[i] * $signed({1'b0, w_s2});
		end
	end

	// Accumulate the sixteen products
	always_ff @(posedge clk) begin
		if (act_s3) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				acc_q[i] <= first_s3 ? ACC_W'(prod_s3[i]) : acc_q[i] + ACC_W'(prod_s3[i]);
			end
		end
	end

	// Round half up, then saturate to the coordinate range
	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			fin_sum[i] = acc_q[i] + HALF_A;
			fin_sh[i]  = fin_sum[i] >>> F;
			if ((&fin_sh[i][ACC_W-1:C-1]) || !(|fin_sh[i][ACC_W-1:C-1])) begin
				fin_val[i] = fin_sh[i][C-1:0];
			end else if (fin_sh[i][ACC_W-1]) begin
				fin_val[i] = {1'b1, {(C - 1){1'b0}}};
			end else begin
				fin_val[i] = {1'b0, {(C - 1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done_s4) begin
			res_q <= fin_val;
		end
	end

	assign done  = done_q;
	assign res_x = res_q[0];
	assign res_y = res_q[1];
	assign res_z = res_q[2];

endmodule

FILE: sv/bicubic_bezier_patch_eval.sv
// Bicubic Bezier patch evaluator: control, weight units, memory/accumulator, output register.
//
// A write item stores one control point in the 4x4 grid and leaves the block
// idle and ready for the next item. An evaluate item closes the input until its
// result is loaded into the output register. The Bernstein weights are computed in
// six steps on the single multiplier of each weight unit; the sixteen control
// points are then read one per cycle from the single read port of the point
// memory, followed by pipeline stages of weighting, accumulation and rounding.
// The output register keeps a finished result, so the next item is taken while
// that result waits for its consumer; a second result waits inside the block
// until the register frees. All points read as zero after reset until written.
// No clearing pass is needed.
`timescale 1ns / 1ps
module bicubic_bezier_patch_eval #(
	parameter int COORD_WIDTH     = 24,
	parameter int PARAM_FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [bbpe_pkg::IDX_W-1:0]    point_index,
	input  logic signed [COORD_WIDTH-1:0] write_x,
	input  logic signed [COORD_WIDTH-1:0] write_y,
	input  logic signed [COORD_WIDTH-1:0] write_z,
	input  logic [PARAM_FRAC_BITS:0]      param_u,
	input  logic [PARAM_FRAC_BITS:0]      param_v,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] surface_x,
	output logic signed [COORD_WIDTH-1:0] surface_y,
	output logic signed [COORD_WIDTH-1:0] surface_z
);
	import bbpe_pkg::*;

	`include "bicubic_bezier_patch_eval_assert.svh"

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_BASIS = 4'b0010,
		ST_ACCUM = 4'b0100,
		ST_HOLD  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic                          in_acc, wr_acc, eval_acc;
	logic                          basis_done_u, basis_done_v, basis_done;
	logic [PARAM_FRAC_BITS:0]      bu [4];
	logic [PARAM_FRAC_BITS:0]      bv [4];
	mac_ctl_t                      mac_ctl;
	logic                          mac_done;
	logic signed [COORD_WIDTH-1:0] res_x, res_y, res_z;
	logic                          out_free, out_load;
	logic                          out_valid_q;
	logic signed [COORD_WIDTH-1:0] surface_x_q, surface_y_q, surface_z_q;

	// Input handshake
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign wr_acc   = in_acc && (operation == OP_WRITE);
	assign eval_acc = in_acc && (operation == OP_EVAL);

	// Weight units for u and v
	bbpe_basis #(.F(PARAM_FRAC_BITS)) u_basis_u (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (eval_acc),
		.param  (param_u),
		.done   (basis_done_u),
		.weight (bu)
	);

	bbpe_basis #(.F(PARAM_FRAC_BITS)) u_basis_v (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (eval_acc),
		.param  (param_v),
		.done   (basis_done_v),
		.weight (bv)
	);

	assign basis_done = basis_done_u && basis_done_v;

	// Point memory and accumulator
	always_comb begin
		mac_ctl.start  = basis_done;
		mac_ctl.wr_en  = wr_acc;
		mac_ctl.wr_idx = point_index;
	end

	bbpe_mac #(.C(COORD_WIDTH), .F(PARAM_FRAC_BITS)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.wr_x   (write_x),
		.wr_y   (write_y),
		.wr_z   (write_z),
		.bu     (bu),
		.bv     (bv),
		.done   (mac_done),
		.res_x  (res_x),
		.res_y  (res_y),
		.res_z  (res_z)
	);

	// Sequencing
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (eval_acc) state_d = ST_BASIS;
			ST_BASIS: if (basis_done) state_d = ST_ACCUM;
			ST_ACCUM: if (mac_done) state_d = out_free ? ST_IDLE : ST_HOLD;
			ST_HOLD:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output register
	assign out_load = out_free &&
		(((state_q == ST_ACCUM) && mac_done) || (state_q == ST_HOLD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			surface_x_q <= res_x;
			surface_y_q <= res_y;
			surface_z_q <= res_z;
		end
	end

	assign out_valid = out_valid_q;
	assign surface_x = surface_x_q;
	assign surface_y = surface_y_q;
	assign surface_z = surface_z_q;

	// Checks
	`BBPE_ASSERT_SAME(a_basis_lockstep, 1'b1, basis_done_u == basis_done_v, "weight units out of step")
	`BBPE_ASSERT_SAME(a_done_in_accum, mac_done, state_q == ST_ACCUM, "sum finished outside accumulation")
	`BBPE_ASSERT_SAME(a_no_write_in_accum, state_q == ST_ACCUM, !mac_ctl.wr_en, "point write during accumulation")
	`BBPE_ASSERT_SAME(a_hold_needs_full, state_q == ST_HOLD, out_valid_q, "holding with output register empty")
	`BBPE_ASSERT_NEXT(a_basis_to_accum, basis_done, state_q == ST_ACCUM, "weights done but no accumulation")

endmodule

FILE: tb/sv/bicubic_bezier_patch_eval_test.sv
// Self-checking testbench for the bicubic Bezier patch evaluator.
`timescale 1ns / 1ps
module bicubic_bezier_patch_eval_test;
	import bbpe_pkg::*;

	localparam int COORD_W = 24;
	localparam int FRAC    = 16;
	localparam logic [FRAC:0] ONE = 17'h10000;
	localparam longint HALF = longint'(1) << (FRAC - 1);
	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam int STALL_LIMIT = 5000;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [FRAC:0]             param_t;
	typedef logic [IDX_W-1:0]          index_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} surface_point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid, in_ready, operation, out_valid, out_ready;
	logic [IDX_W-1:0] point_index;
	logic signed [COORD_W-1:0] write_x, write_y, write_z;
	logic [FRAC:0] param_u, param_v;
	logic signed [COORD_W-1:0] surface_x, surface_y, surface_z;

	// Predictor state: the control point grid, sign-extended
	longint grid_x [NUM_POINTS];
	longint grid_y [NUM_POINTS];
	longint grid_z [NUM_POINTS];
	surface_point_t expected_points [$];
	surface_point_t oldest_point;

	int error_count = 0;
	int items_sent = 0;
	int evals_sent = 0;
	int points_checked = 0;
	int stalled_cycles = 0;
	int hold_len = 0;
	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;

	bicubic_bezier_patch_eval #(
		.COORD_WIDTH(COORD_W),
		.PARAM_FRAC_BITS(FRAC)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.point_index(point_index),
		.write_x(write_x),
		.write_y(write_y),
		.write_z(write_z),
		.param_u(param_u),
		.param_v(param_v),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.surface_x(surface_x),
		.surface_y(surface_y),
		.surface_z(surface_z)
	);

	always #5 clk = ~clk;

	// Q.F product back to Q.F, round half up (operands are non-negative)
	function automatic longint fx_rnd(input longint p);
		return (p + HALF) >>> FRAC;
	endfunction

	// Cubic Bernstein weights for one parameter, clamped to one
	function automatic logic [3:0][31:0] bernstein_weights(input logic [FRAC:0] raw);
		longint t, s, t2, s2;
		logic [3:0][31:0] w;
		t = longint'(raw);
		if (t > longint'(ONE))
			t = longint'(ONE);
		s = longint'(ONE) - t;
		t2 = fx_rnd(t * t);
		s2 = fx_rnd(s * s);
		w[0] = 32'(fx_rnd(s2 * s));
		w[1] = 32'(fx_rnd(3 * t * s2));
		w[2] = 32'(fx_rnd(3 * t2 * s));
		w[3] = 32'(fx_rnd(t2 * t));
		return w;
	endfunction

	// Round the exact sum half up and clip to the coordinate range
	function automatic logic signed [COORD_W-1:0] round_saturate(input longint acc);
		longint r;
		r = (acc + HALF) >>> FRAC;
		if (r > COORD_MAX)
			r = COORD_MAX;
		if (r < COORD_MIN)
			r = COORD_MIN;
		return r[COORD_W-1:0];
	endfunction

	// Weighted sum of all 16 control points at (u, v)
	function automatic surface_point_t predict_surface(input logic [FRAC:0] u, input logic [FRAC:0] v);
		logic [3:0][31:0] bu, bv;
		longint ax, ay, az, wu, wv, w;
		int slot;
		surface_point_t p;
		bu = bernstein_weights(u);
		bv = bernstein_weights(v);
		ax = 0;
		ay = 0;
		az = 0;
		for (int row = 0; row < 4; row++) begin
			for (int col = 0; col < 4; col++) begin
				wu = longint'(bu[col]);
				wv = longint'(bv[row]);
				w = fx_rnd(wu * wv);
				slot = col + 4 * row;
				ax += grid_x[slot] * w;
				ay += grid_y[slot] * w;
				az += grid_z[slot] * w;
			end
		end
		p.x = round_saturate(ax);
		p.y = round_saturate(ay);
		p.z = round_saturate(az);
		return p;
	endfunction

	// Mostly short gaps, a few long ones, none when idling is off
	function automatic int pick_gap(input bit enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return '0;
			3: return '1;
			4: return coord_t'($signed($urandom_range(0, 511)) - 256);
			default: return coord_t'($urandom());
		endcase
	endfunction

	function automatic logic [FRAC:0] rand_param();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return ONE;
			2: return param_t'($urandom_range(ONE + 1, (1 << (FRAC + 1)) - 1));
			3: return $urandom_range(0, 1) ? 17'd1 : ONE - 1;
			default: return param_t'($urandom_range(0, ONE));
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		error_count++;
	endtask

	// Offer one item, wait for acceptance, update the prediction, then idle for a random gap when idling is on
	task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
			input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
			input logic signed [COORD_W-1:0] z, input logic [FRAC:0] u,
			input logic [FRAC:0] v);
		int gap;
		@(negedge clk);
		operation <= op;
		point_index <= idx;
		write_x <= x;
		write_y <= y;
		write_z <= z;
		param_u <= u;
		param_v <= v;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (op == OP_WRITE) begin
			grid_x[idx] = longint'(x);
			grid_y[idx] = longint'(y);
			grid_z[idx] = longint'(z);
		end else begin
			expected_points = {expected_points, predict_surface(u, v)};
			evals_sent++;
		end
		items_sent++;
		gap = pick_gap(tx_idle);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic write_point(input logic [IDX_W-1:0] idx, input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] y, input logic signed [COORD_W-1:0] z);
		send_item(OP_WRITE, idx, x, y, z, param_t'($urandom()), param_t'($urandom()));
	endtask

	task automatic eval_at(input logic [FRAC:0] u, input logic [FRAC:0] v);
		send_item(OP_EVAL, index_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()),
			coord_t'($urandom()), u, v);
	endtask

	// Grid is all zero after reset
	task automatic test_cleared_grid();
		eval_at('0, '0);
		eval_at(ONE / 2, ONE / 3);
	endtask

	// Each corner parameter pair returns its corner point exactly
	task automatic test_corner_points();
		write_point(FIRST_IDX, COORD_MAX, COORD_MIN, '1);
		write_point(4'd3, COORD_MIN, 24'sd1, COORD_MAX);
		write_point(4'd12, 24'sd1, '1, '0);
		write_point(LAST_IDX, '1, COORD_MAX, COORD_MIN);
		eval_at('0, '0);
		eval_at(ONE, '0);
		eval_at('0, ONE);
		eval_at(ONE, ONE);
	endtask

	// u or v above one behaves as one
	task automatic test_param_clamp();
		eval_at('1, '1);
		eval_at(ONE + 1, '0);
		eval_at(ONE / 2, ONE / 2);
	endtask

	// Receiver holds off for a long stretch while evaluations keep coming
	task automatic test_output_backpressure();
		tx_idle = 1'b0;
		hold_len = 400;
		repeat (12) eval_at(rand_param(), rand_param());
	endtask

	// Random grid updates and evaluations, uniform extreme patches, and noise
	task automatic test_random_patches(input int target);
		int start_count;
		logic signed [COORD_W-1:0] fx, fy, fz;
		start_count = items_sent;
		while (items_sent - start_count < target) begin
			tx_idle = ($urandom_range(0, 4) != 0);
			rx_idle = ($urandom_range(0, 4) != 0);
			case ($urandom_range(0, 9)) inside
				[0:4]: begin
					repeat ($urandom_range(1, 16))
						write_point(index_t'($urandom()), rand_coord(), rand_coord(),
							rand_coord());
					repeat ($urandom_range(1, 4)) eval_at(rand_param(), rand_param());
				end
				[5:6]: begin
					// same extreme everywhere: rounded weights may overshoot one
					fx = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
					fy = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
					fz = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
					for (int i = 0; i < NUM_POINTS; i++)
						write_point(index_t'(i), fx, fy, fz);
					repeat (3) eval_at(param_t'($urandom_range(0, ONE)),
						param_t'($urandom_range(0, ONE)));
				end
				default: begin
					repeat ($urandom_range(1, 6))
						send_item(1'($urandom()), index_t'($urandom()), rand_coord(),
							rand_coord(), rand_coord(), param_t'($urandom()),
							param_t'($urandom()));
				end
			endcase
		end
	endtask

	// Result receiver: random stalls, plus a long hold on request
	initial begin
		int n, stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				out_ready <= 1'b0;
				n = hold_len;
				hold_len = 0;
				repeat (n - 1) @(negedge clk);
			end else begin
				stall = pick_gap(rx_idle);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall - 1) @(negedge clk);
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_points.size() == 0) begin
				report_mismatch($sformatf("unexpected result x=%0d y=%0d z=%0d",
					surface_x, surface_y, surface_z));
			end else begin
				oldest_point = expected_points.pop_front();
				if (surface_x !== oldest_point.x)
					report_mismatch($sformatf("surface_x got %0d want %0d",
						surface_x, oldest_point.x));
				if (surface_y !== oldest_point.y)
					report_mismatch($sformatf("surface_y got %0d want %0d",
						surface_y, oldest_point.y));
				if (surface_z !== oldest_point.z)
					report_mismatch($sformatf("surface_z got %0d want %0d",
						surface_z, oldest_point.z));
				points_checked++;
			end
		end
	end

	// Watchdog: too long without any handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stalled_cycles <= 0;
			else
				stalled_cycles <= stalled_cycles + 1;
			if (stalled_cycles >= STALL_LIMIT) begin
				$display("Timeout after %0d cycles with no item moving", STALL_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Test sequence
	initial begin
		in_valid = 1'b0;
		operation = OP_WRITE;
		point_index = '0;
		write_x = '0;
		write_y = '0;
		write_z = '0;
		param_u = '0;
		param_v = '0;
		for (int i = 0; i < NUM_POINTS; i++) begin
			grid_x[i] = 0;
			grid_y[i] = 0;
			grid_z[i] = 0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_cleared_grid();
		test_corner_points();
		test_param_clamp();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		test_random_patches(300);
		test_output_backpressure();
		test_random_patches(300);

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Sent %0d items, %0d of them evaluations; checked %0d surface points",
			items_sent, evals_sent, points_checked);
		$display("Covered corner and clamped parameters, extreme patches, long output hold; %0d mismatches",
			error_count);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
